### rtl/rcf_pkg.sv
// Ring cluster finder: shared constants, run-scan types and helper functions.
// No dependencies; imported by rcf_front and ring_cluster_finder_top.

package rcf_pkg;

	localparam int SENSOR_COUNT = 48;
	localparam int MASK_W       = 48;
	localparam int POS_W        = 6;
	localparam int COUNT_W      = 3;
	localparam int RUN_SLOTS    = 4;
	localparam int RUN_LIMIT    = 3;
	localparam int SLOT_W       = 2;
	localparam int OUT_W        = 56;

	typedef logic [POS_W-1:0]        pos_t;
	typedef logic [SENSOR_COUNT-1:0] vec_t;
	typedef logic [COUNT_W-1:0]      count_t;

	localparam pos_t ABSENT_POS = pos_t'(63);
	localparam pos_t LAST_POS   = pos_t'(SENSOR_COUNT - 1);

	// one scan in flight: edges still to pick and positions picked so far
	typedef struct packed {
		vec_t                   rise;
		vec_t                   fall;
		logic                   first_on;
		logic                   last_on;
		count_t                 nclosed;
		pos_t [RUN_SLOTS-1:0]   st;
		pos_t [RUN_SLOTS-1:0]   en;
	} lane_t;

	typedef struct packed {
		count_t                 count;
		pos_t [RUN_SLOTS-1:0]   st;
		pos_t [RUN_SLOTS-1:0]   en;
		logic                   used_fill;
		logic                   bad;
	} result_t;

	function automatic pos_t first_set(vec_t v);
		pos_t p;
		p = ABSENT_POS;
		for (int i = SENSOR_COUNT - 1; i >= 0; i--) begin
			if (v[i]) begin
				p = pos_t'(i);
			end
		end
		return p;
	endfunction

	// take the lowest rising and falling edge as run slot k
	function automatic lane_t pick_run(lane_t l, logic [SLOT_W-1:0] k);
		lane_t r;
		r = l;
		r.st[k] = first_set(l.rise);
		r.rise  = l.rise & (l.rise - vec_t'(1));
		if (l.fall != '0) begin
			r.en[k]   = first_set(l.fall);
			r.fall    = l.fall & (l.fall - vec_t'(1));
			r.nclosed = l.nclosed + count_t'(1);
		end
		return r;
	endfunction

	function automatic result_t decide(lane_t l);
		result_t r;
		count_t  c;
		count_t  cnt;
		logic    fail;
		c    = l.nclosed;
		cnt  = c;
		fail = (c > count_t'(RUN_LIMIT)) ||
		       ((c == count_t'(RUN_LIMIT)) && l.last_on && !l.first_on);
		r.st = l.st;
		r.en = l.en;
		r.used_fill = 1'b0;
		r.bad = fail;
		if (l.last_on && l.first_on) begin
			// wrapping run: first run takes the open run's start
			r.st[0] = l.st[c[SLOT_W-1:0]];
		end else if (l.last_on && (c < count_t'(RUN_LIMIT))) begin
			r.en[c[SLOT_W-1:0]] = LAST_POS;
			cnt = c + count_t'(1);
		end
		for (int k = 0; k < RUN_SLOTS; k++) begin
			if (fail || (count_t'(k) >= cnt)) begin
				r.st[k] = ABSENT_POS;
				r.en[k] = ABSENT_POS;
			end
		end
		r.count = fail ? '0 : cnt;
		return r;
	endfunction

endpackage

### rtl/ring_cluster_finder_top.sv
// Ring cluster finder top level: five-stage pipeline over rcf_front and the
// run-picking functions. Depends on rcf_pkg and rcf_front.
//
// Usage:
//   s_axis_* carries one sensor mask per request, bit i is sensor i.
//   m_axis_* carries one result per mask: run count, four run start/end
//   slots, at most three used (63 when absent), and fill/unrecognised flags.
//   Both the raw and the filled-in mask are scanned side by side; stage 1
//   finds edges, stages 2 to 5 each pick one run, and stage 5 also
//   settles the wrap-around merge and which scan is reported.
//   A request is taken into stage 1 and its result leaves from stage 5.
//   Throughput: one mask per cycle while the receiver is ready; one run per stage.
//   Each stage holds while the stage after it is full and stalled, so a
//   stalled receiver stops only the occupied stages; empty stages keep
//   taking requests until the pipeline is full. Nothing is lost or repeated.
//   Reset clears all valid bits; the pipeline is then empty and ready.

module ring_cluster_finder_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// sensor_mask[47:0]
	input  logic [rcf_pkg::MASK_W-1:0] s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// cluster_count[2:0], start_0, end_0, start_1, end_1, start_2, end_2,
	// start_3, end_3 (6 bits each), used_fill[51], unrecognised[52], zero pad
	output logic [rcf_pkg::OUT_W-1:0]  m_axis_tdata
);
	import rcf_pkg::*;

	lane_t   raw_in, fil_in;
	lane_t   raw_s1, raw_s2, raw_s3, raw_s4;
	lane_t   fil_s1, fil_s2, fil_s3, fil_s4;
	result_t res_s5;
	result_t raw_res, fil_res, sel_res;
	logic    vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic    rdy1, rdy2, rdy3, rdy4, rdy5;

	rcf_front u_front (
		.mask     (s_axis_tdata[SENSOR_COUNT-1:0]),
		.raw_lane (raw_in),
		.fil_lane (fil_in)
	);

	assign rdy5 = !vld_s5 || m_axis_tready;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;
	assign s_axis_tready = rdy1;

	always_comb begin
		raw_res = decide(pick_run(raw_s4, SLOT_W'(3)));
		fil_res = decide(pick_run(fil_s4, SLOT_W'(3)));
		sel_res = raw_res;
		if (raw_res.bad) begin
			sel_res = fil_res;
			sel_res.used_fill = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= s_axis_tvalid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			raw_s1 <= raw_in;
			fil_s1 <= fil_in;
		end
		if (rdy2) begin
			raw_s2 <= pick_run(raw_s1, SLOT_W'(0));
			fil_s2 <= pick_run(fil_s1, SLOT_W'(0));
		end
		if (rdy3) begin
			raw_s3 <= pick_run(raw_s2, SLOT_W'(1));
			fil_s3 <= pick_run(fil_s2, SLOT_W'(1));
		end
		if (rdy4) begin
			raw_s4 <= pick_run(raw_s3, SLOT_W'(2));
			fil_s4 <= pick_run(fil_s3, SLOT_W'(2));
		end
		if (rdy5) begin
			res_s5 <= sel_res;
		end
	end

	assign m_axis_tvalid = vld_s5;
	assign m_axis_tdata  = {3'b000, res_s5.bad, res_s5.used_fill,
	                        res_s5.en[3], res_s5.st[3], res_s5.en[2], res_s5.st[2],
	                        res_s5.en[1], res_s5.st[1], res_s5.en[0], res_s5.st[0],
	                        res_s5.count};

endmodule

### rtl/rcf_front.sv
// Ring cluster finder front end: fills in the mask and finds run edges
// for the raw and the filled scan. Depends on rcf_pkg.

module rcf_front (
	input  logic [rcf_pkg::SENSOR_COUNT-1:0] mask,
	output rcf_pkg::lane_t                   raw_lane,
	output rcf_pkg::lane_t                   fil_lane
);
	import rcf_pkg::*;

	vec_t filled;

	function automatic lane_t edges(vec_t m);
		lane_t l;
		l.rise     = m & ~{m[SENSOR_COUNT-2:0], 1'b0};
		l.fall     = {1'b0, m[SENSOR_COUNT-2:0] & ~m[SENSOR_COUNT-1:1]};
		l.first_on = m[0];
		l.last_on  = m[SENSOR_COUNT-1];
		l.nclosed  = '0;
		l.st       = {RUN_SLOTS{ABSENT_POS}};
		l.en       = {RUN_SLOTS{ABSENT_POS}};
		return l;
	endfunction

	// off bit with both ring neighbours on turns on
	assign filled = mask | ({mask[SENSOR_COUNT-2:0], mask[SENSOR_COUNT-1]} &
	                        {mask[0], mask[SENSOR_COUNT-1:1]});

	assign raw_lane = edges(mask);
	assign fil_lane = edges(filled);

endmodule
